[src/dsle_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disparity sd estimator package
// Shared types and constants for the Laplace-approximation sd estimator.
// ----------------------------------------------------------------------------
package dsle_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_BLUR_SD     = 3'd0;
  localparam logic [2:0] REG_WINDOW_MULT = 3'd1;
  localparam logic [2:0] REG_MIN_SD      = 3'd2;
  localparam logic [2:0] REG_MAX_SD      = 3'd3;
  localparam logic [2:0] REG_COST_SCALE  = 3'd4;
  localparam logic [2:0] REG_RIGHT_WIDTH = 3'd5;

  // Fixed field and accumulator widths.
  localparam int COST_SUM_W = 48;
  localparam int WGT_SUM_W  = 32;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 16;

  // Back-end divider and square root widths.
  localparam int DIV_NUM_W   = 56;
  localparam int DIV_DEN_W   = 33;
  localparam int SQRT_W      = 36;
  localparam int SQRT_STEPS  = 18;

  typedef struct packed {
    logic [15:0] blur_sd;
    logic [7:0]  window_mult;
    logic [15:0] min_sd;
    logic [15:0] max_sd;
    logic [15:0] cost_scale;
    logic [12:0] right_width;
  } cfg_t;

  // Per-pixel snapshot handed from the front end to the back end.
  typedef struct packed {
    logic                             masked;
    logic [2:0][COST_SUM_W-1:0]       cost_sum;
    logic [2:0][WGT_SUM_W-1:0]        wgt_sum;
  } snap_t;

  typedef enum logic [2:0] {
    F_FILL, F_IDLE, F_WIN, F_DIV, F_RD, F_FIN
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_LOAD, B_DIV, B_CLAMP, B_SQRT, B_OUT
  } back_state_t;

  // Divider operations, in the order the back end runs them.
  typedef enum logic [2:0] {
    OP_NB, OP_NC, OP_NA, OP_CLO, OP_CHI, OP_RCP
  } op_t;

endpackage

[src/dsle_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dsle_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/dsle_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Snapshot queue
// Two-entry queue of per-pixel sums between the front and back ends.
// ----------------------------------------------------------------------------
module dsle_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dsle_pkg::snap_t push_entry,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output dsle_pkg::snap_t head
);
  import dsle_pkg::*;

  snap_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = mem_r[rd_ptr_r];

  // Pointer and count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !full) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop && valid) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    case ({push && !full, pop && valid})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[src/dsle_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample front end
// Fills the Gaussian table, accepts cost samples, windows them, looks up
// the three weights and accumulates the weighted sums of each pixel.
// ----------------------------------------------------------------------------
module dsle_front #(
  parameter int MAX_IMAGE_WIDTH   = 4096,
  parameter int GAUSS_TABLE_DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dsle_pkg::cfg_t              cfg,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [dsle_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                        in_tlast,
  input  logic                        in_tuser,
  output logic                        q_push,
  output dsle_pkg::snap_t             q_entry,
  input  logic                        q_full
);
  import dsle_pkg::*;

  localparam int IW  = $clog2(GAUSS_TABLE_DEPTH);
  localparam int UW  = 21;
  localparam int NW  = UW + IW;
  localparam int DCW = $clog2(IW + 1);

  // Table recurrence constants, Q30.
  localparam logic [63:0] Q30  = 64'd1 << 30;
  localparam logic [63:0] HALF = 64'd1 << 29;
  localparam logic [63:0] DSQ  = 64'(GAUSS_TABLE_DEPTH) * 64'(GAUSS_TABLE_DEPTH);
  localparam logic [63:0] GY   = ((64'd32 << 30) + DSQ / 64'd2) / DSQ;
  localparam logic [63:0] GT2  = ((GY * GY + HALF) >> 30) / 64'd2;
  localparam logic [63:0] GT3  = ((GT2 * GY + HALF) >> 30) / 64'd3;
  localparam logic [63:0] GE1  = Q30 - GY + GT2 - GT3;
  localparam logic [63:0] GE2  = (GE1 * GE1 + HALF) >> 30;

  front_state_t state_r, state_nxt;

  // Table fill.
  logic [IW-1:0] fill_cnt_r;
  logic [30:0]   fw_r, fg_r;
  logic [61:0]   fw_prod, fg_prod;
  logic [31:0]   fw_round;

  // Captured sample.
  logic [11:0]        x_r;
  logic signed [18:0] mean_r;
  logic signed [13:0] d_r;
  logic [15:0]        cost_r;
  logic               masked_r;
  logic               last_r;

  logic [23:0] span_r;
  logic [23:0] c_r;
  logic [15:0] sd_eff;
  logic [16:0] dden;

  // Window.
  logic signed [26:0] mean64, lo_v, hi_v;
  logic signed [15:0] lo, hi, lb, ub, x16, d16;
  logic [12:0]        wdt;
  logic               in_win;

  // Weight index dividers.
  logic signed [UW-1:0] mean21, d64, u [3];
  logic [UW-1:0]        au [3];
  logic [NW-1:0]        num_r [3];
  logic [NW-1:0]        dsh_r;
  logic [IW-1:0]        q_r [3];
  logic [2:0]           zero_r;
  logic [DCW-1:0]       dcnt_r;

  // Lookup and accumulate pipeline.
  logic [2:0]            rd_cnt_r;
  logic [IW-1:0]         raddr;
  logic [15:0]           rdata;
  logic                  rd1_v_r, rd2_v_r;
  logic [1:0]            rd1_k_r, rd2_k_r;
  logic [15:0]           wsel;
  logic [15:0]           w2_r;
  logic [39:0]           prod_r;
  logic [2:0][COST_SUM_W-1:0] cost_sum_r;
  logic [2:0][WGT_SUM_W-1:0]  wgt_sum_r;

  logic fill_done;

  assign sd_eff = (cfg.blur_sd == 16'd0) ? 16'd1 : cfg.blur_sd;
  assign dden   = {sd_eff, 1'b0};

  // Fill recurrence products.
  assign fw_prod  = 62'(fw_r) * 62'(fg_r) + 62'(HALF);
  assign fg_prod  = 62'(fg_r) * 62'(GE2) + 62'(HALF);
  assign fw_round = 32'(fw_r) + 32'h0000_4000;
  assign fill_done = (fill_cnt_r == IW'(GAUSS_TABLE_DEPTH - 1));

  dsle_ram #(
    .WIDTH(16),
    .DEPTH(GAUSS_TABLE_DEPTH)
  ) u_gauss (
    .clk  (clk),
    .we   (state_r == F_FILL),
    .waddr(fill_cnt_r),
    .wdata(fw_round[30:15]),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Window bounds from the captured sample.
  always_comb begin
    mean64 = $signed({{2{mean_r[18]}}, mean_r, 6'b0});
    lo_v   = mean64 - 27'sd4096 - $signed({3'b0, span_r});
    hi_v   = mean64 + 27'sd8191 + $signed({3'b0, span_r});
    lo     = $signed({lo_v[26], lo_v[26:12]});
    hi     = $signed({hi_v[26], hi_v[26:12]});
    if (32'(cfg.right_width) < 32'(MAX_IMAGE_WIDTH)) begin
      wdt = cfg.right_width;
    end else begin
      wdt = 13'(MAX_IMAGE_WIDTH);
    end
    x16 = $signed({4'b0, x_r});
    lb  = -x16;
    ub  = $signed({3'b0, wdt}) - x16;
    if (lo < lb) lo = lb;
    if (lo > ub) lo = ub;
    if (hi < lb) hi = lb;
    if (hi > ub) hi = ub;
    d16    = $signed({{2{d_r[13]}}, d_r});
    in_win = (d16 >= lo) && (d16 <= hi);
  end

  // Offsets from mean-1, mean and mean+1.
  always_comb begin
    mean21 = $signed({{2{mean_r[18]}}, mean_r});
    d64    = $signed({d_r[13], d_r, 6'b0});
    u[0]   = mean21 - 21'sd64 - d64;
    u[1]   = mean21 - d64;
    u[2]   = mean21 + 21'sd64 - d64;
    for (int k = 0; k < 3; k++) begin
      au[k] = u[k][UW-1] ? UW'(-u[k]) : UW'(u[k]);
    end
  end

  // Table read address for the three lookups.
  always_comb begin
    case (rd_cnt_r)
      3'd0:    raddr = q_r[0];
      3'd1:    raddr = q_r[1];
      3'd2:    raddr = q_r[2];
      default: raddr = '0;
    endcase
  end

  assign wsel = zero_r[rd1_k_r] ? 16'd0 : rdata;

  // Next state and handshake outputs.
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    q_push    = 1'b0;
    unique case (state_r)
      F_FILL: begin
        if (fill_done) state_nxt = F_IDLE;
      end
      F_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = F_WIN;
      end
      F_WIN: begin
        state_nxt = in_win ? F_DIV : F_FIN;
      end
      F_DIV: begin
        if (dcnt_r == DCW'(1)) state_nxt = F_RD;
      end
      F_RD: begin
        if (rd_cnt_r == 3'd4) state_nxt = F_FIN;
      end
      F_FIN: begin
        if (!last_r) begin
          state_nxt = F_IDLE;
        end else if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign q_entry.masked   = masked_r;
  assign q_entry.cost_sum = cost_sum_r;
  assign q_entry.wgt_sum  = wgt_sum_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= F_FILL;
      fill_cnt_r <= '0;
      fw_r       <= 31'(Q30);
      fg_r       <= 31'(GE1);
      rd1_v_r    <= 1'b0;
      rd2_v_r    <= 1'b0;
      cost_sum_r <= '0;
      wgt_sum_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_FILL) begin
        fill_cnt_r <= fill_cnt_r + IW'(1);
        fw_r       <= fw_prod[60:30];
        fg_r       <= fg_prod[60:30];
      end
      rd1_v_r <= (state_r == F_RD) && (rd_cnt_r < 3'd3);
      rd2_v_r <= rd1_v_r;
      // Saturating accumulation, cleared once the pixel is handed over.
      if (q_push) begin
        cost_sum_r <= '0;
        wgt_sum_r  <= '0;
      end else if (rd2_v_r) begin
        for (int k = 0; k < 3; k++) begin
          if (rd2_k_r == 2'(k)) begin
            logic [COST_SUM_W:0] cs;
            logic [WGT_SUM_W:0]  ws;
            cs = {1'b0, cost_sum_r[k]} + (COST_SUM_W + 1)'(prod_r);
            ws = {1'b0, wgt_sum_r[k]} + (WGT_SUM_W + 1)'(w2_r);
            cost_sum_r[k] <= cs[COST_SUM_W] ? '1 : cs[COST_SUM_W-1:0];
            wgt_sum_r[k]  <= ws[WGT_SUM_W] ? '1 : ws[WGT_SUM_W-1:0];
          end
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    span_r <= sd_eff * cfg.window_mult;
    if (state_r == F_IDLE && in_tvalid) begin
      x_r      <= in_tdata[11:0];
      mean_r   <= $signed(in_tdata[30:12]);
      d_r      <= $signed(in_tdata[44:31]);
      cost_r   <= in_tdata[60:45];
      masked_r <= in_tuser;
      last_r   <= in_tlast;
    end
    if (state_r == F_WIN) begin
      logic [31:0] cp;
      cp  = 32'(cost_r) * 32'(cfg.cost_scale);
      c_r <= cp[31:8];
      for (int k = 0; k < 3; k++) begin
        zero_r[k] <= (au[k] >= UW'(dden));
        num_r[k]  <= NW'(au[k]) * NW'(GAUSS_TABLE_DEPTH);
        q_r[k]    <= '0;
      end
      dsh_r    <= NW'(dden) << (IW - 1);
      dcnt_r   <= DCW'(IW);
      rd_cnt_r <= 3'd0;
    end
    // One quotient bit per cycle for each of the three indexes.
    if (state_r == F_DIV) begin
      for (int k = 0; k < 3; k++) begin
        if (num_r[k] >= dsh_r) begin
          num_r[k] <= num_r[k] - dsh_r;
          q_r[k]   <= {q_r[k][IW-2:0], 1'b1};
        end else begin
          q_r[k]   <= {q_r[k][IW-2:0], 1'b0};
        end
      end
      dsh_r  <= dsh_r >> 1;
      dcnt_r <= dcnt_r - DCW'(1);
    end
    if (state_r == F_RD) begin
      rd_cnt_r <= rd_cnt_r + 3'd1;
    end
    rd1_k_r <= rd_cnt_r[1:0];
    rd2_k_r <= rd1_k_r;
    w2_r    <= wsel;
    prod_r  <= 40'(wsel) * 40'(c_r);
  end

endmodule

[src/dsle_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel back end
// Normalizes the three sums, forms and clamps the curvature, and takes
// the reciprocal square root with one shared divider and a root unit.
// ----------------------------------------------------------------------------
module dsle_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dsle_pkg::cfg_t                cfg,
  input  logic                          q_valid,
  input  dsle_pkg::snap_t               q_head,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [dsle_pkg::OUT_DATA_W-1:0] out_tdata
);
  import dsle_pkg::*;

  back_state_t state_r, state_nxt;
  op_t         op_r;
  snap_t       snap_r;

  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [5:0]           cnt_r;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 qbit;
  logic [DIV_NUM_W-1:0] quot;

  logic [2:0][DIV_NUM_W-1:0] n_r;
  logic [DIV_DEN_W-1:0]      clo_r, chi_r;

  logic [SQRT_W-1:0] sq_v_r, sq_r_r, sq_bit_r, sq_t, sq_r_nxt;
  logic [SQRT_W-1:0] rr;

  logic [15:0] mn_eff, mx_eff;
  logic [15:0] res_r;
  logic        out_v_r;
  logic [15:0] out_d_r;
  logic        any_zero;

  logic signed [57:0] dd;
  logic [DIV_DEN_W-1:0] dd_c;

  assign mn_eff = (cfg.min_sd == 16'd0) ? 16'd1 : cfg.min_sd;
  assign mx_eff = (cfg.max_sd == 16'd0) ? 16'd1 : cfg.max_sd;

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  assign any_zero = (q_head.wgt_sum[0] == '0) || (q_head.wgt_sum[1] == '0) ||
                    (q_head.wgt_sum[2] == '0);

  // Restoring divide step.
  assign rem_sh = {rem_r, num_r[DIV_NUM_W-1]};
  assign qbit   = (rem_sh >= {1'b0, den_r});
  assign quot   = {num_r[DIV_NUM_W-2:0], qbit};

  // Root step.
  assign sq_t = sq_r_r + sq_bit_r;
  always_comb begin
    if (sq_v_r >= sq_t) begin
      sq_r_nxt = (sq_r_r >> 1) + sq_bit_r;
    end else begin
      sq_r_nxt = sq_r_r >> 1;
    end
    rr = (sq_r_nxt + SQRT_W'(1)) >> 1;
  end

  // Curvature and clamp.
  always_comb begin
    dd = $signed(58'(n_r[0])) + $signed(58'(n_r[2])) - $signed({1'b0, n_r[1], 1'b0});
    if (dd < $signed(58'(clo_r))) dd = $signed(58'(clo_r));
    if (dd > $signed(58'(chi_r))) dd = $signed(58'(chi_r));
    dd_c = dd[DIV_DEN_W-1:0];
  end

  // Next state and queue pop.
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          state_nxt = (q_head.masked || any_zero) ? B_OUT : B_LOAD;
        end
      end
      B_LOAD:  state_nxt = B_DIV;
      B_DIV: begin
        if (cnt_r == 6'd1) begin
          unique case (op_r)
            OP_CHI:  state_nxt = B_CLAMP;
            OP_RCP:  state_nxt = B_SQRT;
            default: state_nxt = B_LOAD;
          endcase
        end
      end
      B_CLAMP: state_nxt = B_DIV;
      B_SQRT: begin
        if (cnt_r == 6'd1) state_nxt = B_OUT;
      end
      B_OUT: begin
        if (!out_v_r || out_tready) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_OUT && (!out_v_r || out_tready)) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (state_r == B_OUT && (!out_v_r || out_tready)) begin
      out_d_r <= res_r;
    end
    unique case (state_r)
      B_IDLE: begin
        snap_r <= q_head;
        op_r   <= OP_NB;
        res_r  <= q_head.masked ? 16'd0 : mx_eff;
      end
      B_LOAD: begin
        rem_r <= '0;
        cnt_r <= 6'(DIV_NUM_W);
        unique case (op_r)
          OP_NB: begin
            num_r <= {snap_r.cost_sum[0], 8'b0};
            den_r <= {1'b0, snap_r.wgt_sum[0]};
          end
          OP_NC: begin
            num_r <= {snap_r.cost_sum[1], 8'b0};
            den_r <= {1'b0, snap_r.wgt_sum[1]};
          end
          OP_NA: begin
            num_r <= {snap_r.cost_sum[2], 8'b0};
            den_r <= {1'b0, snap_r.wgt_sum[2]};
          end
          OP_CLO: begin
            num_r <= DIV_NUM_W'(1) << 32;
            den_r <= DIV_DEN_W'(mx_eff) * DIV_DEN_W'(mx_eff);
          end
          default: begin
            num_r <= DIV_NUM_W'(1) << 32;
            den_r <= DIV_DEN_W'(mn_eff) * DIV_DEN_W'(mn_eff);
          end
        endcase
      end
      B_DIV: begin
        rem_r <= qbit ? DIV_DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DIV_DEN_W-1:0];
        num_r <= quot;
        // The reciprocal hands its count over to the root steps.
        if (cnt_r == 6'd1 && op_r == OP_RCP) begin
          cnt_r <= 6'(SQRT_STEPS);
        end else begin
          cnt_r <= cnt_r - 6'd1;
        end
        if (cnt_r == 6'd1) begin
          unique case (op_r)
            OP_NB:  n_r[0] <= quot;
            OP_NC:  n_r[1] <= quot;
            OP_NA:  n_r[2] <= quot;
            OP_CLO: clo_r  <= DIV_DEN_W'(quot);
            OP_CHI: chi_r  <= DIV_DEN_W'(quot);
            default: begin
              sq_v_r   <= SQRT_W'(quot);
              sq_r_r   <= '0;
              sq_bit_r <= SQRT_W'(1) << 34;
            end
          endcase
          if (op_r != OP_RCP && op_r != OP_CHI) begin
            op_r <= op_t'(op_r + 3'd1);
          end
        end
      end
      B_CLAMP: begin
        num_r <= DIV_NUM_W'(1) << 34;
        den_r <= dd_c;
        rem_r <= '0;
        cnt_r <= 6'(DIV_NUM_W);
        op_r  <= OP_RCP;
      end
      B_SQRT: begin
        if (sq_v_r >= sq_t) begin
          sq_v_r <= sq_v_r - sq_t;
        end
        sq_r_r   <= sq_r_nxt;
        sq_bit_r <= sq_bit_r >> 2;
        cnt_r    <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          res_r <= (rr > SQRT_W'(16'hFFFF)) ? 16'hFFFF : rr[15:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[src/disparity_sd_laplace_estimate_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disparity sd estimator, top level
// Laplace approximation of the disparity standard deviation per pixel.
// ----------------------------------------------------------------------------
// After reset the unit fills its Gaussian table with in_tready low;
// configuration writes are taken at any time. A cost sample inside the
// window occupies the front end while the weight index division retires
// one bit per cycle and the table memory is read once for each of the
// three weights; a sample outside the window skips both. The last sample
// of a pixel hands its sums to a two-entry queue; the back end then runs
// six 56-step divisions and an 18-step square root for each unmasked pixel
// with nonzero weight sums, overlapping the next pixel's samples.
module disparity_sd_laplace_estimate_unit #(
  parameter int MAX_IMAGE_WIDTH   = 4096,
  parameter int GAUSS_TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // tdata: pixel_x[11:0], mean_disparity[30:12], candidate_disparity[44:31],
  //        match_cost[60:45], zero[63:61]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tlast,   // last_sample
  input  logic        in_tuser,   // masked_out
  // tdata: std_dev[15:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import dsle_pkg::*;

  cfg_t  cfg_r;
  logic  q_push, q_full, q_pop, q_valid;
  snap_t q_entry, q_head;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blur_sd     <= 16'd1792;
      cfg_r.window_mult <= 8'd48;
      cfg_r.min_sd      <= 16'd26;
      cfg_r.max_sd      <= 16'd4096;
      cfg_r.cost_scale  <= 16'd256;
      cfg_r.right_width <= 13'd640;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BLUR_SD:     cfg_r.blur_sd     <= cfg_data;
        REG_WINDOW_MULT: cfg_r.window_mult <= cfg_data[7:0];
        REG_MIN_SD:      cfg_r.min_sd      <= cfg_data;
        REG_MAX_SD:      cfg_r.max_sd      <= cfg_data;
        REG_COST_SCALE:  cfg_r.cost_scale  <= cfg_data;
        REG_RIGHT_WIDTH: cfg_r.right_width <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  dsle_front #(
    .MAX_IMAGE_WIDTH  (MAX_IMAGE_WIDTH),
    .GAUSS_TABLE_DEPTH(GAUSS_TABLE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tlast (in_tlast),
    .in_tuser (in_tuser),
    .q_push   (q_push),
    .q_entry  (q_entry),
    .q_full   (q_full)
  );

  dsle_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  dsle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

[src/dsle_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disparity sd estimator port checks
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module dsle_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // The table fill keeps the input closed in the first cycle after reset.
  a_fill_closed: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input ready during table fill");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Configuration writes are never refused.
  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind disparity_sd_laplace_estimate_unit dsle_checker u_dsle_checker (.*);

[tb/tb_disparity_sd_laplace_estimate_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disparity sd estimator testbench
// This bench streams per-pixel runs of cost samples into the estimator while
// the sender bursts and the receiver stalls at random. It predicts each
// standard deviation with a bit-accurate model of the window, Gaussian
// weighting, normalization, clamp and square root, or takes a directed row's
// fixed value, and compares it with the unit's output in order.
// ----------------------------------------------------------------------------
module tb_disparity_sd_laplace_estimate_unit;
  import dsle_pkg::*;

  localparam int IMG_W      = 4096;
  localparam int TAB_DEPTH  = 1024;
  localparam int TAB_BITS   = 10;
  localparam int SETTLE_CYC = 2000;
  localparam int WDOG_LIMIT = 40000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        in_tlast;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  disparity_sd_laplace_estimate_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // One cost sample as seen on the input stream.
  typedef struct {
    logic [11:0] px;
    logic [18:0] mean;
    logic [13:0] cand;
    logic [15:0] cost;
    logic        masked;
    logic        last;
  } sample_t;

  // Directed row: sample plus an optional fixed expectation.
  typedef struct {
    sample_t     s;
    bit          fixed;
    logic [15:0] sd_val;
  } row_t;

  cfg_t        pcfg;
  logic [15:0] gauss_q15 [TAB_DEPTH];
  logic [47:0] cost_acc [3];
  logic [31:0] wgt_acc [3];
  logic [15:0] sd_queue [$];
  int          errors;
  int          idle_cycles;
  bit          draining;
  int          rx_phase;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic [63:0] rnd30(logic [63:0] a, logic [63:0] b);
    return (a * b + 64'd536870912) >> 30;
  endfunction

  // Gaussian table, built with the same Q30 recurrence as the front end.
  task automatic build_gauss();
    logic [63:0] dsq, y, t2, t3, e1, e2, w, g;
    dsq = TAB_DEPTH * TAB_DEPTH;
    y   = ((64'd32 << 30) + dsq / 2) / dsq;
    t2  = rnd30(y, y) / 2;
    t3  = rnd30(t2, y) / 3;
    e1  = (64'd1 << 30) - y + t2 - t3;
    e2  = rnd30(e1, e1);
    w   = 64'd1 << 30;
    g   = e1;
    for (int i = 0; i < TAB_DEPTH; i++) begin
      gauss_q15[i] = 16'((w + (64'd1 << 14)) >> 15);
      w = rnd30(w, g);
      g = rnd30(g, e2);
    end
  endtask

  function automatic longint floor_q12(longint a);
    if (a >= 0) return a / 4096;
    return -((-a + 4095) / 4096);
  endfunction

  function automatic logic [63:0] gauss_weight(longint u, logic [63:0] sd);
    logic [63:0] au, idx;
    au  = (u < 0) ? -u : u;
    idx = (au << TAB_BITS) / (2 * sd);
    if (idx >= TAB_DEPTH) return 0;
    return gauss_q15[idx];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] s, logic [63:0] a,
                                          logic [63:0] mx);
    return (a > mx - s) ? mx : s + a;
  endfunction

  // Predictor: accumulate one sample, queue the sd on the last one.
  task automatic predict_sd(sample_t s);
    longint      x, mean, d, wid, span, lo, hi, nrm [3], dd, clo, chi;
    logic [63:0] sd, mn, mx, c, w, r;
    x    = s.px;
    mean = longint'($signed(s.mean));
    d    = longint'($signed(s.cand));
    sd   = pcfg.blur_sd ? pcfg.blur_sd : 1;
    mn   = pcfg.min_sd ? pcfg.min_sd : 1;
    mx   = pcfg.max_sd ? pcfg.max_sd : 1;
    wid  = (pcfg.right_width < IMG_W) ? pcfg.right_width : IMG_W;
    span = sd * pcfg.window_mult;
    lo   = floor_q12(mean * 64 - 4096 - span);
    hi   = -floor_q12(-(mean * 64 + 4096 + span));
    if (lo < -x) lo = -x;
    if (lo > wid - x) lo = wid - x;
    if (hi < -x) hi = -x;
    if (hi > wid - x) hi = wid - x;
    if (d >= lo && d <= hi) begin
      c = (64'(s.cost) * pcfg.cost_scale) >> 8;
      for (int k = 0; k < 3; k++) begin
        w = gauss_weight(mean + (k - 1) * 64 - d * 64, sd);
        cost_acc[k] = 48'(sat_add(cost_acc[k], w * c, 64'hFFFF_FFFF_FFFF));
        wgt_acc[k]  = 32'(sat_add(wgt_acc[k], w, 64'hFFFF_FFFF));
      end
    end
    if (!s.last) return;
    if (s.masked) begin
      sd_queue.push_back(16'd0);
    end else if (wgt_acc[0] == 0 || wgt_acc[1] == 0 || wgt_acc[2] == 0) begin
      sd_queue.push_back(16'(mx));
    end else begin
      for (int k = 0; k < 3; k++) nrm[k] = (64'(cost_acc[k]) << 8) / wgt_acc[k];
      dd  = nrm[0] + nrm[2] - 2 * nrm[1];
      clo = (64'd1 << 32) / (mx * mx);
      chi = (64'd1 << 32) / (mn * mn);
      if (dd < clo) dd = clo;
      if (dd > chi) dd = chi;
      r = (int_sqrt((64'd1 << 34) / 64'(dd)) + 1) >> 1;
      sd_queue.push_back(r > 65535 ? 16'hFFFF : 16'(r));
    end
    for (int k = 0; k < 3; k++) begin
      cost_acc[k] = 0;
      wgt_acc[k]  = 0;
    end
  endtask

  // Result checking and receiver stall pattern.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (sd_queue.size() == 0) begin
          $display("%0t: unexpected std_dev, expected none, actual %0d", $time, out_tdata);
          errors++;
        end else begin
          if (out_tdata !== sd_queue[0]) begin
            $display("%0t: std_dev mismatch, expected %0d, actual %0d",
                     $time, sd_queue[0], out_tdata);
            errors++;
          end
          void'(sd_queue.pop_front());
        end
      end
      rx_phase <= rx_phase + 1;
      case ((rx_phase / 512) % 3)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 7) == 0) || (rx_phase % 37 > 30);
      endcase
    end
  end

  // Watchdog on cycles without any accepted transfer while a sample waits or the bench drains.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || (!draining && !in_tvalid))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Writes one register; cfg_valid stays high so writes can follow back to back.
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BLUR_SD:     pcfg.blur_sd     = val;
      REG_WINDOW_MULT: pcfg.window_mult = val[7:0];
      REG_MIN_SD:      pcfg.min_sd      = val;
      REG_MAX_SD:      pcfg.max_sd      = val;
      REG_COST_SCALE:  pcfg.cost_scale  = val;
      REG_RIGHT_WIDTH: pcfg.right_width = val[12:0];
      default: ;
    endcase
  endtask

  // Waits for every queued result, then lets the back end settle.
  task automatic wait_idle();
    draining = 1;
    while (sd_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    draining = 0;
  endtask

  // Drives one sample and holds it until accepted; in_tvalid stays high.
  task automatic send_sample(sample_t s);
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, s.cost, s.cand, s.mean, s.px};
    in_tlast  <= s.last;
    in_tuser  <= s.masked;
    do @(posedge clk); while (!in_tready);
    predict_sd(s);
  endtask

  task automatic gap();
    in_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  function automatic sample_t mk(int px, int mean, int cand, int cost, bit m, bit l);
    sample_t s;
    s.px = 12'(px); s.mean = 19'(mean); s.cand = 14'(cand); s.cost = 16'(cost);
    s.masked = m; s.last = l;
    return s;
  endfunction

  // Random pixel run: mostly well-formed windows around a shared mean.
  task automatic send_pixel(int len, ref int sent);
    int px, mean, center;
    sample_t s;
    px     = $urandom_range(0, 4095);
    center = $urandom_range(0, 3) == 0 ? $urandom_range(0, 8191) - 4096
                                       : $urandom_range(0, 60);
    mean   = center * 64 + $urandom_range(0, 63);
    if ($urandom_range(0, 9) == 0) mean = $urandom_range(0, 524287) - 262144;
    for (int i = 0; i < len; i++) begin
      s.px   = (px <= 4095) ? px[11:0] : 12'd0;
      s.mean = mean[18:0];
      s.cand = ($urandom_range(0, 7) == 0) ? 14'($urandom_range(0, 8192) - 4096)
                                           : 14'(center - len / 2 + i);
      s.cost = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
      s.masked = ($urandom_range(0, 11) == 0) || (i != len - 1 && $urandom_range(0, 1));
      s.last = (i == len - 1) || ($urandom_range(0, 60) == 0);
      send_sample(s);
      sent++;
      if ($urandom_range(0, 5) == 0) gap();
    end
  endtask

  task automatic random_phase(int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      send_pixel($urandom_range(1, 12), sent);
      if ($urandom_range(0, 3) == 0) gap();
    end
    in_tvalid <= 1'b0;
  endtask

  row_t rows [$];

  initial begin
    errors     = 0;
    draining   = 0;
    rx_phase   = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    in_tuser   = 1'b0;
    out_tready = 1'b1;
    cfg_valid  = 1'b0;
    cfg_index  = REG_BLUR_SD;
    cfg_data   = '0;
    pcfg = '{blur_sd: 16'd1792, window_mult: 8'd48, min_sd: 16'd26, max_sd: 16'd4096,
             cost_scale: 16'd256, right_width: 13'd640};
    build_gauss();
    for (int k = 0; k < 3; k++) begin
      cost_acc[k] = 0;
      wgt_acc[k]  = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows: masked pixel, empty sums, extremes and normal curves.
    rows.push_back('{mk(0, 0, 0, 0, 1, 1), 1, 16'd0});
    rows.push_back('{mk(4095, 0, 9, 100, 0, 1), 1, 16'd4096});
    rows.push_back('{mk(100, 640, 9, 65535, 0, 0), 0, 0});
    rows.push_back('{mk(100, 640, 10, 0, 0, 0), 0, 0});
    rows.push_back('{mk(100, 640, 11, 65535, 0, 1), 0, 0});
    rows.push_back('{mk(10, 640, 8, 500, 1, 0), 0, 0});
    rows.push_back('{mk(10, 640, 10, 100, 0, 0), 0, 0});
    rows.push_back('{mk(10, 640, 12, 500, 1, 1), 1, 16'd0});
    rows.push_back('{mk(4095, -262144, -4096, 65535, 0, 1), 1, 16'd4096});
    rows.push_back('{mk(0, 262143, 4096, 65535, 0, 1), 1, 16'd4096});
    rows.push_back('{mk(50, 0, 0, 1000, 0, 0), 0, 0});
    rows.push_back('{mk(50, 0, -1, 3000, 0, 0), 0, 0});
    rows.push_back('{mk(50, 0, 1, 3000, 0, 1), 0, 0});
    rows.push_back('{mk(2048, 3200, 50, 7, 1, 0), 0, 0});
    rows.push_back('{mk(2048, 3200, 49, 9000, 0, 0), 0, 0});
    rows.push_back('{mk(2048, 3200, 51, 8000, 0, 1), 0, 0});
    foreach (rows[i]) begin
      if (rows[i].fixed) sd_queue.push_back(rows[i].sd_val);
      send_sample(rows[i].s);
      if (rows[i].fixed) void'(sd_queue.pop_back());
      if (i % 3 == 2) gap();
    end
    in_tvalid <= 1'b0;
    wait_idle();

    // Extreme register settings, each set followed by random traffic.
    write_reg(REG_BLUR_SD, 16'd0);
    write_reg(REG_WINDOW_MULT, 16'd255);
    write_reg(REG_MIN_SD, 16'd0);
    write_reg(REG_MAX_SD, 16'hFFFF);
    write_reg(REG_COST_SCALE, 16'hFFFF);
    write_reg(REG_RIGHT_WIDTH, 16'd4096);
    cfg_valid <= 1'b0;
    random_phase(300);
    wait_idle();

    write_reg(REG_BLUR_SD, 16'hFFFF);
    write_reg(REG_WINDOW_MULT, 16'd0);
    write_reg(REG_MIN_SD, 16'd5000);
    write_reg(REG_MAX_SD, 16'd300);
    write_reg(REG_COST_SCALE, 16'd0);
    write_reg(REG_RIGHT_WIDTH, 16'd1);
    write_reg(3'd7, 16'h1234);
    cfg_valid <= 1'b0;
    random_phase(250);
    wait_idle();

    write_reg(REG_RIGHT_WIDTH, 16'h1FFF);
    write_reg(REG_COST_SCALE, 16'd256);
    write_reg(REG_MIN_SD, 16'd1);
    write_reg(REG_MAX_SD, 16'd0);
    write_reg(REG_BLUR_SD, 16'd64);
    write_reg(REG_WINDOW_MULT, 16'd16);
    cfg_valid <= 1'b0;
    random_phase(300);
    wait_idle();

    write_reg(REG_BLUR_SD, 16'd1792);
    write_reg(REG_WINDOW_MULT, 16'd48);
    write_reg(REG_MIN_SD, 16'd26);
    write_reg(REG_MAX_SD, 16'd4096);
    write_reg(REG_COST_SCALE, 16'($urandom_range(1, 65535)));
    write_reg(REG_RIGHT_WIDTH, 16'd640);
    cfg_valid <= 1'b0;
    random_phase(1050);
    wait_idle();

    if (errors == 0 && sd_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
